[rtl/iti_pkg.sv]
// Shared types, constants and anchor tables for the identifier-to-time interpolator.
// Holds the command and status structs between iti_ctrl and iti_datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package iti_pkg;

  localparam int unsigned ANCHOR_COUNT       = 75;
  localparam int unsigned IDENT_BITS_DEFAULT = 40;
  localparam int unsigned PROD_W             = 64;
  localparam int unsigned SECS_W             = 32;
  localparam int unsigned MUL_STEPS          = 32;
  localparam int unsigned DIV_STEPS          = 64;
  localparam int unsigned CNT_W              = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_FIRST   = 2'd1,
    ST_LAST    = 2'd2,
    ST_INTERP  = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic search;
    logic mul_init;
    logic mul_step;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic search_done;
  } stat_t;

  typedef logic [63:0] ident_rom_t [ANCHOR_COUNT];
  typedef logic [31:0] date_rom_t  [ANCHOR_COUNT];
  typedef logic [31:0] time_rom_t  [ANCHOR_COUNT];

  localparam ident_rom_t ANCHOR_IDENT = '{
    64'd0,          64'd2768409,    64'd7679610,    64'd11538514,   64'd15835244,
    64'd23646077,   64'd38015510,   64'd44634663,   64'd46145305,   64'd54845238,
    64'd63263518,   64'd101260938,  64'd101323197,  64'd103151531,  64'd109393468,
    64'd112594714,  64'd124872445,  64'd125828524,  64'd133909606,  64'd143445125,
    64'd148670295,  64'd152079341,  64'd171295414,  64'd181783990,  64'd222021233,
    64'd225034354,  64'd278941742,  64'd285253072,  64'd294851037,  64'd297621225,
    64'd328594461,  64'd337808429,  64'd341546272,  64'd352940995,  64'd369669043,
    64'd400169472,  64'd805158066,  64'd1974255900, 64'd5022636255, 64'd5045293264,
    64'd5047148663, 64'd5144324763, 64'd5159326926, 64'd5340744210, 64'd5472518401,
    64'd5559594088, 64'd5567880858, 64'd5738347976, 64'd5854845236, 64'd5891297818,
    64'd5904140174, 64'd6000582627, 64'd6188508923, 64'd6326011828, 64'd6401027363,
    64'd6451891234, 64'd6513268158, 64'd6536173556, 64'd6559717847, 64'd6606876583,
    64'd6651640269, 64'd6872061796, 64'd7078066115, 64'd7273085448, 64'd7342300216,
    64'd7591351660, 64'd7708562823, 64'd7817256746, 64'd7834356221, 64'd7912577935,
    64'd8017192943, 64'd8117852491, 64'd8209194945, 64'd8480708838, 64'd8559682245
  };

  // dates as yyyymmdd
  localparam date_rom_t ANCHOR_DATE = '{
    32'd20130814, 32'd20131101, 32'd20131231, 32'd20140201, 32'd20140220,
    32'd20140226, 32'd20140301, 32'd20140506, 32'd20140515, 32'd20140920,
    32'd20141027, 32'd20150306, 32'd20150313, 32'd20150603, 32'd20150808,
    32'd20150815, 32'd20150817, 32'd20151005, 32'd20151007, 32'd20151201,
    32'd20160108, 32'd20160122, 32'd20160309, 32'd20160410, 32'd20160608,
    32'd20160618, 32'd20160910, 32'd20161018, 32'd20161119, 32'd20161216,
    32'd20170128, 32'd20170221, 32'd20170222, 32'd20170224, 32'd20170331,
    32'd20170731, 32'd20190715, 32'd20211012, 32'd20211210, 32'd20220113,
    32'd20220405, 32'd20220406, 32'd20220616, 32'd20221026, 32'd20221102,
    32'd20221110, 32'd20230125, 32'd20230425, 32'd20230427, 32'd20230504,
    32'd20230520, 32'd20230530, 32'd20230622, 32'd20230707, 32'd20231125,
    32'd20231202, 32'd20231202, 32'd20240111, 32'd20240225, 32'd20240317,
    32'd20240518, 32'd20240525, 32'd20240908, 32'd20241121, 32'd20250116,
    32'd20250321, 32'd20250510, 32'd20250618, 32'd20250901, 32'd20250915,
    32'd20251005, 32'd20251014, 32'd20251026, 32'd20251105, 32'd20251111
  };

  // Midnight UTC seconds of a proleptic Gregorian date, evaluated at elaboration.
  function automatic logic [31:0] midnight_seconds(input logic [31:0] ymd);
    longint y;
    longint m;
    longint d;
    longint yy;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    longint days;
    longint secs;
    y    = longint'(ymd) / 10000;
    m    = (longint'(ymd) / 100) % 100;
    d    = longint'(ymd) % 100;
    yy   = (m <= 2) ? y - 1 : y;
    era  = yy / 400;
    yoe  = yy - era * 400;
    mp   = (m > 2) ? m - 3 : m + 9;
    doy  = (153 * mp + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    secs = days * 86400;
    return secs[31:0];
  endfunction

  function automatic time_rom_t build_time_rom();
    time_rom_t rom;
    for (int i = 0; i < ANCHOR_COUNT; i++) begin
      rom[i] = midnight_seconds(ANCHOR_DATE[i]);
    end
    return rom;
  endfunction

  localparam time_rom_t ANCHOR_TIME = build_time_rom();

endpackage

[rtl/iti_datapath.sv]
// Datapath of the interpolator: classification, binary anchor search,
// shift-add multiplier, restoring divider and output register.
// Depends on iti_pkg; driven by iti_ctrl.
`timescale 1ns / 1ps

module iti_datapath #(
  parameter int unsigned IDENT_BITS = iti_pkg::IDENT_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  iti_pkg::cmd_t         cmd_i,
  output iti_pkg::stat_t        stat_o,
  input  logic [IDENT_BITS-1:0] user_ident_i,
  output logic [1:0]            result_status_o,
  output logic [31:0]           estimated_seconds_o
);
  import iti_pkg::*;

  localparam int unsigned IdxW = $clog2(ANCHOR_COUNT);

  logic [IDENT_BITS-1:0] id_q;
  status_e               status_q;
  logic [SECS_W-1:0]     clamp_q;
  logic [IdxW-1:0]       lo_q, hi_q;
  logic [IDENT_BITS-1:0] span_q;
  logic                  span_zero_q;
  logic [SECS_W-1:0]     lo_t_q;
  logic                  neg_q;
  logic [PROD_W-1:0]     mcand_q, prod_q;
  logic [SECS_W-1:0]     mplier_q, quo_q;
  logic [IDENT_BITS-1:0] rem_q;
  logic [1:0]            out_status_q;
  logic [SECS_W-1:0]     out_secs_q;

  logic [IDENT_BITS-1:0] first_id, last_id, mid_id, lo_id, hi_id, off, span;
  logic [63:0]           mid_raw, lo_raw, hi_raw;
  logic [IdxW:0]         mid_sum;
  logic [IdxW-1:0]       mid_idx, lo_idx;
  logic [SECS_W-1:0]     lo_t, hi_t, dt, secs_interp;
  logic                  invalid, below_first, above_last;
  logic [IDENT_BITS:0]   trial, diff;
  logic                  fits;

  always_comb begin
    first_id    = ANCHOR_IDENT[0][IDENT_BITS-1:0];
    last_id     = ANCHOR_IDENT[ANCHOR_COUNT-1][IDENT_BITS-1:0];
    invalid     = (id_q == '0) || id_q[IDENT_BITS-1];
    below_first = id_q <= first_id;
    above_last  = id_q >= last_id;

    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid_idx = mid_sum[IdxW:1];
    mid_raw = ANCHOR_IDENT[mid_idx];
    mid_id  = mid_raw[IDENT_BITS-1:0];

    lo_idx  = hi_q - IdxW'(1);
    lo_raw  = ANCHOR_IDENT[lo_idx];
    hi_raw  = ANCHOR_IDENT[hi_q];
    lo_id   = lo_raw[IDENT_BITS-1:0];
    hi_id   = hi_raw[IDENT_BITS-1:0];
    lo_t    = ANCHOR_TIME[lo_idx];
    hi_t    = ANCHOR_TIME[hi_q];
    dt      = (hi_t >= lo_t) ? (hi_t - lo_t) : (lo_t - hi_t);
    off     = id_q - lo_id;
    span    = hi_id - lo_id;

    trial = {rem_q, prod_q[PROD_W-1]};
    diff  = trial - {1'b0, span_q};
    fits  = trial >= {1'b0, span_q};

    if (span_zero_q) begin
      secs_interp = lo_t_q;
    end else if (neg_q) begin
      secs_interp = lo_t_q - quo_q;
    end else begin
      secs_interp = lo_t_q + quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q <= user_ident_i;
    end
    if (cmd_i.check) begin
      lo_q <= IdxW'(1);
      hi_q <= IdxW'(ANCHOR_COUNT - 1);
      if (invalid) begin
        status_q <= ST_INVALID;
        clamp_q  <= '0;
      end else if (below_first) begin
        status_q <= ST_FIRST;
        clamp_q  <= ANCHOR_TIME[0];
      end else if (above_last) begin
        status_q <= ST_LAST;
        clamp_q  <= ANCHOR_TIME[ANCHOR_COUNT-1];
      end else begin
        status_q <= ST_INTERP;
        clamp_q  <= '0;
      end
    end
    if (cmd_i.search) begin
      if (id_q <= mid_id) begin
        hi_q <= mid_idx;
      end else begin
        lo_q <= mid_idx + IdxW'(1);
      end
    end
    if (cmd_i.mul_init) begin
      span_q      <= span;
      span_zero_q <= span == '0;
      lo_t_q      <= lo_t;
      neg_q       <= hi_t < lo_t;
      mcand_q     <= PROD_W'(off);
      mplier_q    <= dt;
      prod_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[SECS_W-1:1]};
    end
    if (cmd_i.div_step) begin
      rem_q  <= fits ? diff[IDENT_BITS-1:0] : trial[IDENT_BITS-1:0];
      prod_q <= {prod_q[PROD_W-2:0], 1'b0};
      quo_q  <= {quo_q[SECS_W-2:0], fits};
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_secs_q   <= (status_q == ST_INTERP) ? secs_interp : clamp_q;
    end
  end

  assign stat_o.special     = invalid || below_first || above_last;
  assign stat_o.search_done = lo_q == hi_q;

  assign result_status_o     = out_status_q;
  assign estimated_seconds_o = out_secs_q;

endmodule

[rtl/iti_ctrl.sv]
// Controller of the interpolator: sequences check, search, multiply and divide,
// and owns both handshakes. Depends on iti_pkg.
`timescale 1ns / 1ps

module iti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iti_pkg::cmd_t  cmd_o,
  input  iti_pkg::stat_t stat_i
);
  import iti_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SEARCH = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.special ? S_DONE : S_SEARCH;
      end
      S_SEARCH: begin
        if (stat_i.search_done) begin
          cmd_o.mul_init = 1'b1;
          cnt_d          = CNT_W'(MUL_STEPS - 1);
          state_d        = S_MUL;
        end else begin
          cmd_o.search = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/id_to_time_table_interpolator.sv]
// Identifier-to-time interpolator over a fixed 75-entry anchor table.
// An item passes through check, binary search, setup, the multiply steps, the divide steps
// and the load; a clamped or invalid item goes from check straight to the load.
// The next input is taken the cycle after the load, so an item is accepted only after the
// last one is loaded; the serial divider is the longest step. A stalled result holds the next
// item in its load step. Reset clears the controller only.
`timescale 1ns / 1ps

module id_to_time_table_interpolator #(
  parameter int unsigned IDENT_BITS = iti_pkg::IDENT_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IDENT_BITS-1:0] user_ident_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            result_status_o,
  output logic [31:0]           estimated_seconds_o
);
  import iti_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  iti_datapath #(
    .IDENT_BITS (IDENT_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .user_ident_i        (user_ident_i),
    .result_status_o     (result_status_o),
    .estimated_seconds_o (estimated_seconds_o)
  );

endmodule

[rtl/iti_checker.sv]
// Port-level checker for the interpolator, bound to the top level.
// Depends on iti_pkg and id_to_time_table_interpolator.
`timescale 1ns / 1ps

module iti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_status_o,
  input logic [31:0] estimated_seconds_o
);
  import iti_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_status_o) && $stable(estimated_seconds_o))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_status_o == ST_INVALID) |-> estimated_seconds_o == '0)
    else $error("invalid result carries nonzero seconds");

  a_clamp_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((result_status_o != ST_FIRST) || (estimated_seconds_o == ANCHOR_TIME[0])) &&
      ((result_status_o != ST_LAST)  ||
       (estimated_seconds_o == ANCHOR_TIME[ANCHOR_COUNT-1])))
    else $error("clamped result differs from anchor time");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second input taken while busy");

endmodule

bind id_to_time_table_interpolator iti_checker u_iti_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .result_status_o     (result_status_o),
  .estimated_seconds_o (estimated_seconds_o)
);

[verif/tb.sv]
// Testbench for id_to_time_table_interpolator: directed table rows, then random identifiers.
// Checks fixed rows against stored values, others against a piecewise linear anchor predictor.
// Depends on iti_pkg for the status type and the identifier width.
`timescale 1ns / 1ps

module tb;
  import iti_pkg::*;

  localparam int IDENT_W   = IDENT_BITS_DEFAULT;
  localparam int KNOT_NUM  = 75;
  localparam int RAND_ITEMS = 1250;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [31:0] LAST_KNOT_SECS = 32'd1762819200;

  localparam logic [63:0] KNOT_ID [KNOT_NUM] = '{
    64'd0,          64'd2768409,    64'd7679610,    64'd11538514,   64'd15835244,
    64'd23646077,   64'd38015510,   64'd44634663,   64'd46145305,   64'd54845238,
    64'd63263518,   64'd101260938,  64'd101323197,  64'd103151531,  64'd109393468,
    64'd112594714,  64'd124872445,  64'd125828524,  64'd133909606,  64'd143445125,
    64'd148670295,  64'd152079341,  64'd171295414,  64'd181783990,  64'd222021233,
    64'd225034354,  64'd278941742,  64'd285253072,  64'd294851037,  64'd297621225,
    64'd328594461,  64'd337808429,  64'd341546272,  64'd352940995,  64'd369669043,
    64'd400169472,  64'd805158066,  64'd1974255900, 64'd5022636255, 64'd5045293264,
    64'd5047148663, 64'd5144324763, 64'd5159326926, 64'd5340744210, 64'd5472518401,
    64'd5559594088, 64'd5567880858, 64'd5738347976, 64'd5854845236, 64'd5891297818,
    64'd5904140174, 64'd6000582627, 64'd6188508923, 64'd6326011828, 64'd6401027363,
    64'd6451891234, 64'd6513268158, 64'd6536173556, 64'd6559717847, 64'd6606876583,
    64'd6651640269, 64'd6872061796, 64'd7078066115, 64'd7273085448, 64'd7342300216,
    64'd7591351660, 64'd7708562823, 64'd7817256746, 64'd7834356221, 64'd7912577935,
    64'd8017192943, 64'd8117852491, 64'd8209194945, 64'd8480708838, 64'd8559682245
  };

  localparam int KNOT_YMD [KNOT_NUM] = '{
    20130814, 20131101, 20131231, 20140201, 20140220, 20140226, 20140301, 20140506,
    20140515, 20140920, 20141027, 20150306, 20150313, 20150603, 20150808, 20150815,
    20150817, 20151005, 20151007, 20151201, 20160108, 20160122, 20160309, 20160410,
    20160608, 20160618, 20160910, 20161018, 20161119, 20161216, 20170128, 20170221,
    20170222, 20170224, 20170331, 20170731, 20190715, 20211012, 20211210, 20220113,
    20220405, 20220406, 20220616, 20221026, 20221102, 20221110, 20230125, 20230425,
    20230427, 20230504, 20230520, 20230530, 20230622, 20230707, 20231125, 20231202,
    20231202, 20240111, 20240225, 20240317, 20240518, 20240525, 20240908, 20241121,
    20250116, 20250321, 20250510, 20250618, 20250901, 20250915, 20251005, 20251014,
    20251026, 20251105, 20251111
  };

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic               fixed;
    status_e            st;
    logic [31:0]        secs;
  } stim_row_t;

  localparam int DIR_ROWS = 22;
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{40'd0,              1'b1, ST_INVALID, 32'd0},
    '{40'hFF_FFFF_FFFF,   1'b1, ST_INVALID, 32'd0},
    '{40'h80_0000_0000,   1'b1, ST_INVALID, 32'd0},
    '{40'hAA_AAAA_AAAA,   1'b1, ST_INVALID, 32'd0},
    '{40'h7F_FFFF_FFFF,   1'b1, ST_LAST,    LAST_KNOT_SECS},
    '{40'h55_5555_5555,   1'b1, ST_LAST,    LAST_KNOT_SECS},
    '{40'd8559682245,     1'b1, ST_LAST,    LAST_KNOT_SECS},
    '{40'd8559682246,     1'b1, ST_LAST,    LAST_KNOT_SECS},
    '{40'd8559682244,     1'b0, ST_INTERP,  32'd0},
    '{40'd1,              1'b0, ST_INTERP,  32'd0},
    '{40'd2768409,        1'b0, ST_INTERP,  32'd0},
    '{40'd2768410,        1'b0, ST_INTERP,  32'd0},
    '{40'd400169473,      1'b0, ST_INTERP,  32'd0},
    '{40'd1974255901,     1'b0, ST_INTERP,  32'd0},
    '{40'h00_FFFF_FFFF,   1'b0, ST_INTERP,  32'd0},
    '{40'h01_0000_0000,   1'b0, ST_INTERP,  32'd0},
    '{40'd5022636254,     1'b0, ST_INTERP,  32'd0},
    '{40'd6451891234,     1'b0, ST_INTERP,  32'd0},
    '{40'd6480000000,     1'b0, ST_INTERP,  32'd0},
    '{40'd6513268158,     1'b0, ST_INTERP,  32'd0},
    '{40'd8480708838,     1'b0, ST_INTERP,  32'd0},
    '{40'd8480708839,     1'b0, ST_INTERP,  32'd0}
  };

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    status_e            st;
    logic [31:0]        secs;
  } estimate_t;

  typedef enum int {
    RDY_OPEN,
    RDY_COIN,
    RDY_SPARSE,
    RDY_BURSTY
  } ready_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [IDENT_W-1:0] user_ident_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         result_status_o;
  logic [31:0]        estimated_seconds_o;

  logic               row_fixed;
  status_e            row_status;
  logic [31:0]        row_secs;

  logic [31:0]        knot_secs [KNOT_NUM];
  estimate_t          pending_estimates [$];
  int                 errors;
  int                 idle_cycles;
  int                 burst_left;

  id_to_time_table_interpolator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .user_ident_i        (user_ident_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_status_o     (result_status_o),
    .estimated_seconds_o (estimated_seconds_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] midnight_utc(input int ymd);
    int     y;
    int     m;
    int     d;
    longint days;
    bit     leap;
    y    = ymd / 10000;
    m    = (ymd / 100) % 100;
    d    = ymd % 100;
    days = 0;
    for (int yr = 1970; yr < y; yr++) begin
      days += (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 366 : 365;
    end
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    for (int mo = 1; mo < m; mo++) begin
      case (mo)
        2:             days += leap ? 29 : 28;
        4, 6, 9, 11:   days += 30;
        default:       days += 31;
      endcase
    end
    days += d - 1;
    return 32'(days * 86400);
  endfunction

  function automatic estimate_t interpolate_time(input logic [IDENT_W-1:0] ident);
    estimate_t   est;
    logic [63:0] u;
    logic [63:0] off;
    logic [63:0] span;
    logic [63:0] lo_t;
    logic [63:0] hi_t;
    int          k;
    est.ident = ident;
    u = 64'(ident);
    if (ident == '0 || ident[IDENT_W-1]) begin
      est.st   = ST_INVALID;
      est.secs = '0;
    end else if (u <= KNOT_ID[0]) begin
      est.st   = ST_FIRST;
      est.secs = knot_secs[0];
    end else if (u >= KNOT_ID[KNOT_NUM-1]) begin
      est.st   = ST_LAST;
      est.secs = knot_secs[KNOT_NUM-1];
    end else begin
      k = 1;
      while (k < KNOT_NUM - 1 && u > KNOT_ID[k]) k++;
      span = KNOT_ID[k] - KNOT_ID[k-1];
      off  = u - KNOT_ID[k-1];
      lo_t = 64'(knot_secs[k-1]);
      hi_t = 64'(knot_secs[k]);
      est.st = ST_INTERP;
      if (span == 0) begin
        est.secs = lo_t[31:0];
      end else if (hi_t >= lo_t) begin
        est.secs = 32'(lo_t + (off * (hi_t - lo_t)) / span);
      end else begin
        est.secs = 32'(lo_t - (off * (lo_t - hi_t)) / span);
      end
    end
    return est;
  endfunction

  function automatic logic [IDENT_W-1:0] random_ident();
    logic [63:0] r;
    logic [63:0] v;
    int          pick;
    int          seg;
    pick = $urandom_range(0, 99);
    r    = {$urandom, $urandom};
    if (pick < 70) begin
      seg = $urandom_range(0, KNOT_NUM - 2);
      v   = KNOT_ID[seg] + 64'd1 + r % (KNOT_ID[seg+1] - KNOT_ID[seg]);
    end else if (pick < 80) begin
      seg = $urandom_range(0, KNOT_NUM - 1);
      v   = KNOT_ID[seg] + 64'($urandom_range(0, 4)) - 64'd2;
    end else if (pick < 90) begin
      v = r;
    end else if (pick < 95) begin
      v = r;
      v[IDENT_W-1] = 1'b1;
    end else begin
      v = KNOT_ID[KNOT_NUM-1] + 64'(r[31:0]);
    end
    return v[IDENT_W-1:0];
  endfunction

  task automatic send_ident(input logic [IDENT_W-1:0] ident, input logic fixed,
                            input status_e st, input logic [31:0] secs);
    in_valid_i   <= 1'b1;
    user_ident_i <= ident;
    row_fixed    <= fixed;
    row_status   <= st;
    row_secs     <= secs;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic hold_gap(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case ($urandom_range(0, 3))
        0:       hold_gap(0);
        1:       hold_gap($urandom_range(40, 150));
        default: hold_gap($urandom_range(1, 20));
      endcase
    end
  endtask

  initial begin
    ready_mode_e mode;
    int          span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 300);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          RDY_OPEN:   out_ready_i <= 1'b1;
          RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:    out_ready_i <= (k % 24 == 23);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d seconds %0d",
                   $time, result_status_o, estimated_seconds_o);
          errors++;
        end else begin
          want = pending_estimates.pop_front();
          if (result_status_o !== want.st) begin
            $display("%0t: ident %0d status: expected %0d, actual %0d",
                     $time, want.ident, want.st, result_status_o);
            errors++;
          end
          if (estimated_seconds_o !== want.secs) begin
            $display("%0t: ident %0d seconds: expected %0d, actual %0d",
                     $time, want.ident, want.secs, estimated_seconds_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        idle_cycles = 0;
        if (row_fixed) begin
          pending_estimates.push_back('{ident: user_ident_i, st: row_status, secs: row_secs});
        end else begin
          pending_estimates.push_back(interpolate_time(user_ident_i));
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    errors       = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    user_ident_i = '0;
    row_fixed    = 1'b0;
    row_status   = ST_INVALID;
    row_secs     = '0;
    for (int k = 0; k < KNOT_NUM; k++) begin
      knot_secs[k] = midnight_utc(KNOT_YMD[k]);
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_ident(DIRECTED_ROWS[k].ident, DIRECTED_ROWS[k].fixed,
                 DIRECTED_ROWS[k].st, DIRECTED_ROWS[k].secs);
      pace();
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        hold_gap(1);
        while (pending_estimates.size() != 0) @(negedge clk_i);
      end
      send_ident(random_ident(), 1'b0, ST_INTERP, '0);
      pace();
    end

    hold_gap(1);
    while (pending_estimates.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
